// ===== rtl/gap_buffer_text_store_macros.svh =====
// Assertion macros shared by the gap buffer text store RTL.
`ifndef GAP_BUFFER_TEXT_STORE_MACROS_SVH
`define GAP_BUFFER_TEXT_STORE_MACROS_SVH

// Checked on every rising clock edge, ignored while reset is high.
`define GBTS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define GBTS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/gbts_pkg.sv =====
// Shared types, field widths and codes of the gap buffer text store.
package gbts_pkg;

   localparam int CAPACITY_DEF = 1024;

   localparam int CHAR_W   = 16;
   localparam int MODE_W   = 3;
   localparam int AMOUNT_W = 12;
   localparam int POS_W    = 10;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;

   localparam logic [MODE_W-1:0] MODE_INSERT    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BACKSPACE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MOVE      = 3'd2;
   localparam logic [MODE_W-1:0] MODE_READ      = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_WRITABLE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL         = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_AT_START     = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic [CHAR_W-1:0]          char_value;
      logic signed [AMOUNT_W-1:0] move_amount;
      logic [POS_W-1:0]           position;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  moved_count;
      logic [CHAR_W-1:0]   char_out;
      logic [COUNT_W-1:0]  text_length;
      logic [COUNT_W-1:0]  cursor_pos;
   } rsp_type;

endpackage

// ===== rtl/gbts_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module gbts_ram #(
   parameter int WIDTH = gbts_pkg::CHAR_W,
   parameter int DEPTH = gbts_pkg::CAPACITY_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gap_buffer_text_store.sv =====
// Top level of the gap buffer text store: sequencer, shared adder and two stores.
//
//   channel   ports                            handshake
//   request   start, busy, req_data            beat taken when start & !busy
//   response  rsp_strobe, rsp_data             one-cycle strobe, no back-pressure
//   control   csr_valid, csr_ready, csr_data   beat taken when valid & ready
//
// Insert, backspace, clear and unused modes end in ST_EXEC. A read ends in ST_EXEC
// when out of range, passes ST_RDSEL and ST_RDWAIT before the cursor, and ST_RDSEL,
// ST_RDIDX and ST_RDWAIT after it. A move by zero ends in ST_EXEC; others use the
// adder in ST_EXEC, ST_AVAIL and ST_CLAMP, then copy in ST_MVISSUE and drain in
// ST_MVDRAIN when at least one character moves. The result strobe follows the last
// busy cycle. Reset is synchronous; the stores are not cleared and need no pass.
`include "gap_buffer_text_store_macros.svh"

module gap_buffer_text_store #(
   parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gbts_pkg::req_type req_data,
   output logic              rsp_strobe,
   output gbts_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import gbts_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int UW = ((CW > AMOUNT_W) ? CW : AMOUNT_W) + 1;

   localparam logic [CW-1:0]        CAP_C = CW'(CAPACITY);
   localparam logic signed [UW-1:0] CAP_U = UW'(CAPACITY);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RDSEL,
      ST_RDIDX,
      ST_RDWAIT,
      ST_AVAIL,
      ST_CLAMP,
      ST_MVISSUE,
      ST_MVDRAIN
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   rsp_data_ff, rsp_data_in;
   logic      rsp_strobe_ff, rsp_strobe_in;
   logic      writable_ff, writable_in;
   logic [CW-1:0] before_count_ff, before_count_in;
   logic [CW-1:0] after_start_ff, after_start_in;
   logic [CW-1:0] stored_count_ff, stored_count_in;
   logic signed [UW-1:0] tmp_ff, tmp_in;
   logic signed [UW-1:0] avail_ff, avail_in;
   logic signed [UW-1:0] count_ff, count_in;
   logic signed [UW-1:0] moved_ff, moved_in;
   logic      dir_left_ff, dir_left_in;
   logic      rd_after_ff, rd_after_in;
   logic      wr_pend_ff, wr_pend_in;
   logic [AW-1:0] wr_addr_ff, wr_addr_in;

   logic signed [UW-1:0] alu_a, alu_b, alu_sum;
   logic                 alu_sub, alu_neg;

   logic          b_we, a_we;
   logic [AW-1:0] b_waddr, b_raddr, a_raddr;
   logic [CHAR_W-1:0] b_wdata, b_rdata, a_rdata;

   logic [CW-1:0] bc_dec, as_dec;
   logic signed [UW-1:0] clamp_n, moved_v;
   logic          done;
   logic [STATUS_W-1:0] status_v;
   logic [CHAR_W-1:0]   char_v;
   logic signed [UW-1:0] gap_chk;

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   assign bc_dec = before_count_ff - CW'(1);
   assign as_dec = after_start_ff - CW'(1);

   // Operand selection for the shared adder.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_EXEC: begin
            if (req_ff.mode == MODE_READ) begin
               alu_a   = UW'(req_ff.position);
               alu_b   = UW'(stored_count_ff);
               alu_sub = 1'b1;
            end else if (req_ff.move_amount[AMOUNT_W-1]) begin
               alu_b   = UW'(req_ff.move_amount);
               alu_sub = 1'b1;
            end else begin
               alu_a = UW'(req_ff.move_amount);
            end
         end
         ST_RDSEL: begin
            alu_a   = UW'(req_ff.position);
            alu_b   = UW'(before_count_ff);
            alu_sub = 1'b1;
         end
         ST_RDIDX: begin
            alu_a = tmp_ff;
            alu_b = UW'(after_start_ff);
         end
         ST_AVAIL: begin
            if (dir_left_ff) begin
               alu_a = UW'(before_count_ff);
            end else begin
               alu_a   = CAP_U;
               alu_b   = UW'(after_start_ff);
               alu_sub = 1'b1;
            end
         end
         ST_CLAMP: begin
            alu_a   = tmp_ff;
            alu_b   = avail_ff;
            alu_sub = 1'b1;
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
   assign alu_neg = alu_sum[UW-1];
   assign clamp_n = alu_neg ? tmp_ff : avail_ff;

   always_comb begin
      state_in        = state_ff;
      req_in          = req_ff;
      writable_in     = writable_ff;
      before_count_in = before_count_ff;
      after_start_in  = after_start_ff;
      stored_count_in = stored_count_ff;
      tmp_in          = tmp_ff;
      avail_in        = avail_ff;
      count_in        = count_ff;
      moved_in        = moved_ff;
      dir_left_in     = dir_left_ff;
      rd_after_in     = rd_after_ff;
      wr_addr_in      = wr_addr_ff;
      wr_pend_in      = 1'b0;
      rsp_strobe_in   = 1'b0;
      rsp_data_in     = rsp_data_ff;

      b_we    = wr_pend_ff && !dir_left_ff;
      b_waddr = wr_addr_ff;
      b_wdata = a_rdata;
      b_raddr = AW'(req_ff.position);
      a_we    = wr_pend_ff && dir_left_ff;
      a_raddr = AW'(alu_sum);

      done     = 1'b0;
      status_v = STATUS_OK;
      char_v   = '0;
      moved_v  = '0;

      if (csr_valid && csr_ready) begin
         writable_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (req_ff.mode)
               MODE_INSERT: begin
                  done = 1'b1;
                  if (!writable_ff) begin
                     status_v = STATUS_NOT_WRITABLE;
                  end else if (stored_count_ff >= CAP_C) begin
                     status_v = STATUS_FULL;
                  end else begin
                     b_we            = 1'b1;
                     b_waddr         = before_count_ff[AW-1:0];
                     b_wdata         = req_ff.char_value;
                     before_count_in = before_count_ff + CW'(1);
                     stored_count_in = stored_count_ff + CW'(1);
                  end
               end
               MODE_BACKSPACE: begin
                  done = 1'b1;
                  if (before_count_ff == '0) begin
                     status_v = STATUS_AT_START;
                  end else begin
                     before_count_in = bc_dec;
                     stored_count_in = stored_count_ff - CW'(1);
                  end
               end
               MODE_MOVE: begin
                  if (req_ff.move_amount == '0) begin
                     done = 1'b1;
                  end else begin
                     dir_left_in = req_ff.move_amount[AMOUNT_W-1];
                     tmp_in      = alu_sum;
                     state_in    = ST_AVAIL;
                  end
               end
               MODE_READ: begin
                  if (!alu_neg) begin
                     done = 1'b1;
                  end else begin
                     state_in = ST_RDSEL;
                  end
               end
               MODE_CLEAR: begin
                  done            = 1'b1;
                  before_count_in = '0;
                  after_start_in  = CAP_C;
                  stored_count_in = '0;
               end
               default: begin
                  done = 1'b1;
               end
            endcase
         end
         ST_RDSEL: begin
            if (alu_neg) begin
               rd_after_in = 1'b0;
               state_in    = ST_RDWAIT;
            end else begin
               tmp_in   = alu_sum;
               state_in = ST_RDIDX;
            end
         end
         ST_RDIDX: begin
            rd_after_in = 1'b1;
            state_in    = ST_RDWAIT;
         end
         ST_RDWAIT: begin
            done   = 1'b1;
            char_v = rd_after_ff ? a_rdata : b_rdata;
         end
         ST_AVAIL: begin
            avail_in = alu_sum;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (clamp_n == '0) begin
               done = 1'b1;
            end else begin
               count_in = clamp_n;
               moved_in = clamp_n;
               state_in = ST_MVISSUE;
            end
         end
         ST_MVISSUE: begin
            wr_pend_in = 1'b1;
            count_in   = count_ff - UW'(1);
            if (dir_left_ff) begin
               b_raddr         = bc_dec[AW-1:0];
               wr_addr_in      = as_dec[AW-1:0];
               before_count_in = bc_dec;
               after_start_in  = as_dec;
            end else begin
               a_raddr         = after_start_ff[AW-1:0];
               wr_addr_in      = before_count_ff[AW-1:0];
               before_count_in = before_count_ff + CW'(1);
               after_start_in  = after_start_ff + CW'(1);
            end
            if (count_ff == UW'(1)) begin
               state_in = ST_MVDRAIN;
            end
         end
         ST_MVDRAIN: begin
            done    = 1'b1;
            moved_v = moved_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done) begin
         state_in                = ST_IDLE;
         rsp_strobe_in           = 1'b1;
         rsp_data_in.status      = status_v;
         rsp_data_in.moved_count = COUNT_W'(moved_v);
         rsp_data_in.char_out    = char_v;
         rsp_data_in.text_length = COUNT_W'(stored_count_in);
         rsp_data_in.cursor_pos  = COUNT_W'(before_count_in);
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_data_ff <= rsp_data_in;
      tmp_ff      <= tmp_in;
      avail_ff    <= avail_in;
      count_ff    <= count_in;
      moved_ff    <= moved_in;
      dir_left_ff <= dir_left_in;
      rd_after_ff <= rd_after_in;
      wr_addr_ff  <= wr_addr_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_strobe_ff   <= 1'b0;
         writable_ff     <= 1'b1;
         before_count_ff <= '0;
         after_start_ff  <= CAP_C;
         stored_count_ff <= '0;
         wr_pend_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rsp_strobe_ff   <= rsp_strobe_in;
         writable_ff     <= writable_in;
         before_count_ff <= before_count_in;
         after_start_ff  <= after_start_in;
         stored_count_ff <= stored_count_in;
         wr_pend_ff      <= wr_pend_in;
      end
   end

   gbts_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CAPACITY)
   ) u_before_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (b_waddr),
      .wr_data (b_wdata),
      .rd_addr (b_raddr),
      .rd_data (b_rdata)
   );

   gbts_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CAPACITY)
   ) u_after_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr_ff),
      .wr_data (b_rdata),
      .rd_addr (a_raddr),
      .rd_data (a_rdata)
   );

   assign gap_chk = UW'(before_count_ff) + CAP_U - UW'(after_start_ff);

   `GBTS_ASSERT(a_count_invariant, gap_chk == UW'(stored_count_ff), "gap bookkeeping broken")
   `GBTS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not start work")
   `GBTS_ASSERT(a_strobe_after_work, rsp_strobe |-> (!busy && $past(busy)),
      "result strobe without finished work")

endmodule

// ===== tb/gap_buffer_text_store_checker.sv =====
// Predicts each command of the gap buffer text store and compares the response beats.
module gap_buffer_text_store_checker #(
   parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  gbts_pkg::req_type req_data,
   input  logic              rsp_strobe,
   input  gbts_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic              csr_data,
   output int                pending,
   output int                fail_count
);
   import gbts_pkg::*;

   logic [CHAR_W-1:0] head_chars [CAPACITY];
   logic [CHAR_W-1:0] tail_chars [CAPACITY];
   int unsigned       head_len;
   int unsigned       tail_start;
   int unsigned       text_len;
   logic              write_enable;
   rsp_type           awaited_rsp [$];

   function automatic rsp_type edit_outcome(req_type cmd);
      rsp_type                res;
      int unsigned            want;
      int unsigned            moved;
      int unsigned            pos;
      int unsigned            idx;
      logic [AMOUNT_W-1:0]    amount;
      res = '0;
      moved = 0;
      amount = cmd.move_amount;
      pos = cmd.position;
      case (cmd.mode)
         MODE_INSERT: begin
            if (!write_enable) begin
               res.status = STATUS_NOT_WRITABLE;
            end else if (text_len >= CAPACITY || head_len >= CAPACITY) begin
               res.status = STATUS_FULL;
            end else begin
               head_chars[head_len] = cmd.char_value;
               head_len++;
               text_len++;
            end
         end
         MODE_BACKSPACE: begin
            if (head_len == 0) begin
               res.status = STATUS_AT_START;
            end else begin
               head_len--;
               text_len--;
            end
         end
         MODE_MOVE: begin
            if (amount[AMOUNT_W-1]) begin
               want = (1 << AMOUNT_W) - amount;
               while (moved < want && head_len > 0 && tail_start > 0) begin
                  head_len--;
                  tail_start--;
                  tail_chars[tail_start] = head_chars[head_len];
                  moved++;
               end
            end else begin
               want = amount;
               while (moved < want && tail_start < CAPACITY && head_len < CAPACITY) begin
                  head_chars[head_len] = tail_chars[tail_start];
                  head_len++;
                  tail_start++;
                  moved++;
               end
            end
            res.moved_count = COUNT_W'(moved);
         end
         MODE_READ: begin
            if (pos < text_len) begin
               if (pos >= head_len) begin
                  idx = pos - head_len + tail_start;
                  res.char_out = (idx < CAPACITY) ? tail_chars[idx] : '0;
               end else begin
                  res.char_out = head_chars[pos];
               end
            end
         end
         MODE_CLEAR: begin
            head_len = 0;
            tail_start = CAPACITY;
            text_len = 0;
         end
         default: begin
         end
      endcase
      res.text_length = COUNT_W'(text_len);
      res.cursor_pos = COUNT_W'(head_len);
      return res;
   endfunction

   task automatic compare_beat(input rsp_type want, input rsp_type got);
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         fail_count++;
      end
      if (got.moved_count !== want.moved_count) begin
         $error("moved_count: expected %0d, actual %0d", want.moved_count, got.moved_count);
         fail_count++;
      end
      if (got.char_out !== want.char_out) begin
         $error("char_out: expected %h, actual %h", want.char_out, got.char_out);
         fail_count++;
      end
      if (got.text_length !== want.text_length) begin
         $error("text_length: expected %0d, actual %0d", want.text_length, got.text_length);
         fail_count++;
      end
      if (got.cursor_pos !== want.cursor_pos) begin
         $error("cursor_pos: expected %0d, actual %0d", want.cursor_pos, got.cursor_pos);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type oldest;
      if (reset) begin
         head_len = 0;
         tail_start = CAPACITY;
         text_len = 0;
         write_enable = 1'b1;
         awaited_rsp.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            write_enable = csr_data;
         end
         if (rsp_strobe) begin
            if (awaited_rsp.size() == 0) begin
               $error("response beat arrived with no command outstanding");
               fail_count++;
            end else begin
               oldest = awaited_rsp.pop_front();
               compare_beat(oldest, rsp_data);
            end
         end
         if (start && !busy) begin
            awaited_rsp.push_back(edit_outcome(req_data));
         end
      end
      pending = awaited_rsp.size();
   end

endmodule

// ===== tb/tb_gap_buffer_text_store.sv =====
// Stimulus, clocking and verdict for the gap buffer text store regression.
module tb_gap_buffer_text_store;
   import gbts_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;
   int      pending;
   int      fail_count;
   int      stall_cycles;
   int      mode_hits [8];
   int      csr_writes;
   bit      idle_enable;

   gap_buffer_text_store DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   gap_buffer_text_store_checker edit_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .pending    (pending),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic do_edit(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                          input int amount, input logic [POS_W-1:0] pos);
      req_type cmd;
      cmd.mode = mode;
      cmd.char_value = ch;
      cmd.move_amount = AMOUNT_W'(amount);
      cmd.position = pos;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (busy !== 1'b0);
      @(negedge clock);
      mode_hits[mode]++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_writable(input logic value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   function automatic int random_amount();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         return $urandom_range(0, 2048) - 1024;
      end else if (pick == 1) begin
         return $urandom_range(0, 4095);
      end
      return $urandom_range(0, 32) - 16;
   endfunction

   task automatic random_edit();
      int                  sel;
      logic [MODE_W-1:0]   mode;
      logic [POS_W-1:0]    pos;
      sel = $urandom_range(0, 99);
      if (sel < 38) begin
         mode = MODE_INSERT;
      end else if (sel < 55) begin
         mode = MODE_BACKSPACE;
      end else if (sel < 75) begin
         mode = MODE_MOVE;
      end else if (sel < 94) begin
         mode = MODE_READ;
      end else if (sel < 96) begin
         mode = MODE_CLEAR;
      end else begin
         mode = MODE_W'($urandom_range(5, 7));
      end
      pos = $urandom_range(0, 1) ? POS_W'($urandom) : POS_W'($urandom_range(0, 63));
      do_edit(mode, CHAR_W'($urandom), random_amount(), pos);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      idle_enable = 1'b1;
      csr_writes = 0;
      foreach (mode_hits[m]) mode_hits[m] = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      write_writable(1'b1);
      do_edit(MODE_BACKSPACE, '0, 0, '0);
      do_edit(MODE_READ, '0, 0, '0);
      do_edit(MODE_MOVE, '0, 0, '0);
      do_edit(MODE_MOVE, '0, -1024, '0);
      do_edit(MODE_MOVE, '0, 1024, '0);
      do_edit(MODE_INSERT, 16'h0000, 0, '0);
      do_edit(MODE_INSERT, 16'hFFFF, 0, '0);
      do_edit(MODE_INSERT, 16'h1234, 0, '0);
      do_edit(MODE_MOVE, '0, -1, '0);
      do_edit(MODE_MOVE, '0, -1024, '0);
      do_edit(MODE_READ, '0, 0, 10'd0);
      do_edit(MODE_READ, '0, 0, 10'd2);
      do_edit(MODE_READ, '0, 0, 10'd1023);
      do_edit(MODE_MOVE, '0, 1024, '0);
      do_edit(MODE_MOVE, '0, 2047, '0);
      do_edit(MODE_MOVE, '0, -2048, '0);
      do_edit(MODE_BACKSPACE, 16'hFFFF, 2047, 10'h3FF);
      do_edit(MODE_W'(5), 16'hFFFF, -1, 10'h3FF);
      do_edit(MODE_W'(6), '0, 0, '0);
      do_edit(MODE_W'(7), 16'hA5A5, 1024, 10'd512);
      do_edit(MODE_CLEAR, '0, 0, '0);
      write_writable(1'b0);
      do_edit(MODE_INSERT, 16'hBEEF, 0, '0);
      do_edit(MODE_BACKSPACE, '0, 0, '0);
      do_edit(MODE_CLEAR, '0, 0, '0);

      write_writable(1'b1);
      do_edit(MODE_MOVE, '0, -1024, '0);
      do_edit(MODE_READ, '0, 0, 10'd0);
      do_edit(MODE_READ, '0, 0, 10'd1023);
      do_edit(MODE_INSERT, 16'h7FFF, 0, '0);
      do_edit(MODE_MOVE, '0, 1024, '0);
      do_edit(MODE_READ, '0, 0, 10'd1023);
      do_edit(MODE_MOVE, '0, -2048, '0);
      do_edit(MODE_MOVE, '0, 2047, '0);

      for (int phase = 0; phase < 6; phase++) begin
         if (phase == 1) begin
            write_writable(1'b0);
         end else if (phase == 5) begin
            write_writable(1'b1);
         end else begin
            write_writable($urandom_range(0, 3) != 0);
         end
         idle_enable = (phase != 2) && (phase != 5);
         repeat (103) random_edit();
      end

      wait_drained();
      repeat (16) @(negedge clock);
      $display("Ran %0d inserts, %0d backspaces, %0d moves, %0d reads, %0d clears",
               mode_hits[MODE_INSERT], mode_hits[MODE_BACKSPACE], mode_hits[MODE_MOVE],
               mode_hits[MODE_READ], mode_hits[MODE_CLEAR]);
      $display("and %0d unused mode codes, with %0d writes of the writable bit.",
               mode_hits[5] + mode_hits[6] + mode_hits[7], csr_writes);
      if (fail_count == 0 && pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
